@@ rtl/core/urd_pkg.sv @@
package urd_pkg;

    // fixed field widths
    localparam int WORD_W     = 31;
    localparam int VALUE_W    = 32;
    localparam int MIN_W      = 31;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // draw tag stored beside each offset, all ones is the last before a sweep
    localparam int EPOCH_W = 8;

    localparam logic [CNT_W-1:0] RANGE_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALUE  = 2'd0,
        CFG_RANGE_SIZE = 2'd1,
        CFG_DRAW_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_RDJ,
        ST_WRI,
        ST_WRJ
    } t_state;

endpackage

@@ rtl/core/urd_req_if.sv @@
interface urd_req_if;
    import urd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

@@ rtl/core/urd_res_if.sv @@
interface urd_res_if;
    import urd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] drawn_value;
    logic               last;

    modport source (output valid, output drawn_value, output last, input ready);
    modport sink   (input valid, input drawn_value, input last, output ready);
endinterface

@@ rtl/core/urd_ram.sv @@
module urd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/urd_rem.sv @@
module urd_rem #(
    parameter int DIV_W = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [urd_pkg::WORD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_rem
);
    import urd_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W:0]    trial;

    // one quotient bit per cycle, restoring form, quotient discarded
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[WORD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = DIV_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = DIV_W'(trial);
            end
            n_dvd = {r_dvd[WORD_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/unique_random_draw_by_swap_unit.sv @@
// channel   | port     | direction | payload
// ----------+----------+-----------+-------------------------------------------
// request   | i_req    | in        | random_word (31 bit)
// result    | o_res    | out       | drawn_value (32 bit), last (1 bit)
// config    | i_cfg_*  | in        | idx 0 min_value, 1 range_size, 2 draw_count
//
// one transaction at a time: each request runs the 31-step serial remainder
// plus two reads and two writes of the single-port-pair offset store before
// the next request is taken
// a sweep over every entry clears the store after reset, and again each
// time the 8-bit draw tag runs out (every 255 draws); no request is taken then
// a full result register holds the step in its write phase until taken
module unique_random_draw_by_swap_unit #(
    parameter int RANGE_MAX = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [urd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [urd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    urd_req_if.sink                       i_req,
    urd_res_if.source                     o_res
);
    import urd_pkg::*;

    localparam int AW = $clog2(RANGE_MAX);        // store address / offset width
    localparam int RW = $clog2(RANGE_MAX + 1);    // step index and range width
    localparam int XW = (RW > CNT_W) ? RW : CNT_W;
    localparam int EW = EPOCH_W + AW;             // store entry: {tag, offset}

    // configuration registers
    logic [MIN_W-1:0] r_min;
    logic [CNT_W-1:0] r_range;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_range <= RANGE_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_VALUE:  r_min   <= i_cfg_data[MIN_W-1:0];
                CFG_RANGE_SIZE: r_range <= i_cfg_data[CNT_W-1:0];
                CFG_DRAW_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective range and count: zero reads as one, range saturates,
    // count clamps to the range
    logic [XW-1:0] range_x, count_x;
    logic [RW-1:0] eff_range, eff_count;

    always_comb begin
        range_x = XW'(r_range);
        if (range_x == '0) begin
            range_x = XW'(1);
        end else if (range_x > XW'(RANGE_MAX)) begin
            range_x = XW'(RANGE_MAX);
        end
        eff_range = RW'(range_x);
        count_x   = XW'(r_count);
        if (count_x == '0) begin
            count_x = XW'(1);
        end else if (count_x > range_x) begin
            count_x = range_x;
        end
        eff_count = RW'(count_x);
    end

    // control and datapath registers
    t_state             r_state, n_state;
    logic [RW-1:0]      r_step, n_step;
    logic               r_fresh, n_fresh;     // next step opens a new draw
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_clr_ret, n_clr_ret; // sweep returns to start of a step
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [AW-1:0]      r_j, n_j;
    logic [AW-1:0]      r_at_i, n_at_i;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    // store and remainder unit hookup
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic          div_start, div_done;
    logic [RW-1:0] div_rem;
    logic [RW-1:0] divisor;

    // decoded read: an entry whose tag is not this draw's reads as its own offset
    logic          rd_hit;
    logic [AW-1:0] rd_off;
    logic          fin;

    assign rd_hit  = (mem_rdata[EW-1:AW] == r_epoch);
    assign divisor = eff_range - r_step;
    assign fin     = ((RW+1)'(r_step) + (RW+1)'(1)) >= (RW+1)'(eff_count);

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.drawn_value = r_out_value;
    assign o_res.last        = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_fresh     = r_fresh;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_clr_ret   = r_clr_ret;
        n_out_valid = r_out_valid;
        n_word      = r_word;
        n_j         = r_j;
        n_at_i      = r_at_i;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_clr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_step[AW-1:0];
        div_start   = 1'b0;
        rd_off      = r_step[AW-1:0];

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // tag zero marks an entry stale for every live draw
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(RANGE_MAX - 1)) begin
                    n_clr   = '0;
                    n_epoch = '0;
                    n_fresh = 1'b1;
                    n_state = r_clr_ret ? ST_START : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_word = i_req.random_word;
                    // config shrank below the current position: new draw
                    if (r_step >= eff_count) begin
                        n_step  = '0;
                        n_fresh = 1'b1;
                    end
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_fresh && (r_epoch == '1)) begin
                    n_clr_ret = 1'b1;
                    n_state   = ST_CLEAR;
                end else begin
                    if (r_fresh) begin
                        n_epoch = r_epoch + 1'b1;
                        n_fresh = 1'b0;
                    end
                    div_start = 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_step[AW-1:0];
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_j     = AW'(div_rem + r_step);
                    n_state = ST_RDJ;
                end
            end
            ST_RDJ: begin
                // read data still holds entry i here
                rd_off    = r_step[AW-1:0];
                n_at_i    = rd_hit ? mem_rdata[AW-1:0] : rd_off;
                mem_re    = 1'b1;
                mem_raddr = r_j;
                n_state   = ST_WRI;
            end
            ST_WRI: begin
                rd_off    = r_j;
                mem_we    = 1'b1;
                mem_waddr = r_step[AW-1:0];
                mem_wdata = {r_epoch, (rd_hit ? mem_rdata[AW-1:0] : rd_off)};
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = VALUE_W'(r_min)
                                + VALUE_W'(rd_hit ? mem_rdata[AW-1:0] : rd_off);
                    n_out_last  = fin;
                    n_state     = ST_WRJ;
                end
            end
            ST_WRJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = {r_epoch, r_at_i};
                if (fin) begin
                    n_step  = '0;
                    n_fresh = 1'b1;
                end else begin
                    n_step = r_step + 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_step      <= '0;
            r_fresh     <= 1'b1;
            r_epoch     <= '0;
            r_clr       <= '0;
            r_clr_ret   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_fresh     <= n_fresh;
            r_epoch     <= n_epoch;
            r_clr       <= n_clr;
            r_clr_ret   <= n_clr_ret;
            r_out_valid <= n_out_valid;
        end
        r_word      <= n_word;
        r_j         <= n_j;
        r_at_i      <= n_at_i;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    urd_ram #(
        .WIDTH (EW),
        .DEPTH (RANGE_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    urd_rem #(
        .DIV_W (RW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_word),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

endmodule
